// ===== sv/cbal_pkg.sv =====
// ----------------------------------------------------------------------------
// cbal_pkg
// Shared constants, codes and types of the cubic Bezier arc-length evaluator.
// ----------------------------------------------------------------------------
package cbal_pkg;

  localparam int SEGMENTS = 30;
  localparam int IDX_W    = $clog2(SEGMENTS + 1);
  localparam int COORD_W  = 16;
  localparam int T_W      = 17;
  localparam int LEN_W    = 19;
  localparam int VAL_W    = 19;
  localparam int CMD_W    = 2;
  localparam int ST_W     = 2;
  localparam int OP_W     = 5;
  localparam int MUL_W    = 5;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_REGS  = 8;

  localparam logic [T_W-1:0]   ONE_Q16 = 17'h10000;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam int SQRT_STEPS = 17;
  localparam int DIV_STEPS  = 17;
  localparam int EVAL_LAST  = 15;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PARAM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DIST  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FRAC  = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVER      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_BUILT = 2'd2;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
  localparam logic [OP_W-1:0] OP_LATCH      = 5'd1;
  localparam logic [OP_W-1:0] OP_T_SAMPLE   = 5'd2;
  localparam logic [OP_W-1:0] OP_T_VALUE    = 5'd3;
  localparam logic [OP_W-1:0] OP_T_INTERP   = 5'd4;
  localparam logic [OP_W-1:0] OP_T_RUN      = 5'd5;
  localparam logic [OP_W-1:0] OP_ROUND      = 5'd6;
  localparam logic [OP_W-1:0] OP_BUILD_INIT = 5'd7;
  localparam logic [OP_W-1:0] OP_PREV       = 5'd8;
  localparam logic [OP_W-1:0] OP_SQRT_INIT  = 5'd9;
  localparam logic [OP_W-1:0] OP_SQRT_STEP  = 5'd10;
  localparam logic [OP_W-1:0] OP_ACCUM      = 5'd11;
  localparam logic [OP_W-1:0] OP_READY      = 5'd12;
  localparam logic [OP_W-1:0] OP_DIST_VALUE = 5'd13;
  localparam logic [OP_W-1:0] OP_SCAN_INIT  = 5'd14;
  localparam logic [OP_W-1:0] OP_SCAN_CHK   = 5'd15;
  localparam logic [OP_W-1:0] OP_DIV_INIT   = 5'd16;
  localparam logic [OP_W-1:0] OP_DIV_STEP   = 5'd17;

  // multiplier operand selects, also the write-back tag
  localparam logic [MUL_W-1:0] M_NONE = 5'd0;
  localparam logic [MUL_W-1:0] M_UU   = 5'd1;
  localparam logic [MUL_W-1:0] M_TT   = 5'd2;
  localparam logic [MUL_W-1:0] M_UUU  = 5'd3;
  localparam logic [MUL_W-1:0] M_UUT  = 5'd4;
  localparam logic [MUL_W-1:0] M_UTT  = 5'd5;
  localparam logic [MUL_W-1:0] M_TTT  = 5'd6;
  localparam logic [MUL_W-1:0] M_W0X  = 5'd7;
  localparam logic [MUL_W-1:0] M_W0Y  = 5'd8;
  localparam logic [MUL_W-1:0] M_W1X  = 5'd9;
  localparam logic [MUL_W-1:0] M_W1Y  = 5'd10;
  localparam logic [MUL_W-1:0] M_W2X  = 5'd11;
  localparam logic [MUL_W-1:0] M_W2Y  = 5'd12;
  localparam logic [MUL_W-1:0] M_W3X  = 5'd13;
  localparam logic [MUL_W-1:0] M_W3Y  = 5'd14;
  localparam logic [MUL_W-1:0] M_DXX  = 5'd15;
  localparam logic [MUL_W-1:0] M_DYY  = 5'd16;
  localparam logic [MUL_W-1:0] M_FRAC = 5'd17;
  localparam logic [MUL_W-1:0] M_SPAN = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [MUL_W-1:0] mul;
    logic             out_load;
    logic             out_zero;
    logic [ST_W-1:0]  status;
  } cbal_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             value_over;
    logic             ready;
    logic             hit;
    logic             idx_last;
    logic             out_busy;
  } cbal_stat_t;

  // round(i * 65536 / SEGMENTS)
  function automatic logic [T_W-1:0] sample_param(input logic [IDX_W-1:0] i);
    logic [T_W-1:0] r;
    case (i)
      5'd0:  r = 17'd0;
      5'd1:  r = 17'd2185;
      5'd2:  r = 17'd4369;
      5'd3:  r = 17'd6554;
      5'd4:  r = 17'd8738;
      5'd5:  r = 17'd10923;
      5'd6:  r = 17'd13107;
      5'd7:  r = 17'd15292;
      5'd8:  r = 17'd17476;
      5'd9:  r = 17'd19661;
      5'd10: r = 17'd21845;
      5'd11: r = 17'd24030;
      5'd12: r = 17'd26214;
      5'd13: r = 17'd28399;
      5'd14: r = 17'd30583;
      5'd15: r = 17'd32768;
      5'd16: r = 17'd34953;
      5'd17: r = 17'd37137;
      5'd18: r = 17'd39322;
      5'd19: r = 17'd41506;
      5'd20: r = 17'd43691;
      5'd21: r = 17'd45875;
      5'd22: r = 17'd48060;
      5'd23: r = 17'd50244;
      5'd24: r = 17'd52429;
      5'd25: r = 17'd54613;
      5'd26: r = 17'd56798;
      5'd27: r = 17'd58982;
      5'd28: r = 17'd61167;
      5'd29: r = 17'd63351;
      5'd30: r = 17'd65536;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/cbal_dp.sv =====
// ----------------------------------------------------------------------------
// cbal_dp
// Datapath: config registers, shared multiplier, square root and divide
// steps, length table memory and the output register.
// ----------------------------------------------------------------------------
module cbal_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  cbal_pkg::cbal_cmd_t                cmd,
  output cbal_pkg::cbal_stat_t               stat,
  input  logic                               cfg_valid,
  input  logic [cbal_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbal_pkg::COORD_W-1:0]       cfg_data,
  input  logic [23:0]                        s_tdata,
  input  logic [cbal_pkg::CMD_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [55:0]                        m_tdata,
  output logic [cbal_pkg::ST_W-1:0]          m_tuser
);

  localparam int IW = cbal_pkg::IDX_W;
  localparam int LW = cbal_pkg::LEN_W;
  localparam int TW = cbal_pkg::T_W;
  localparam logic [cbal_pkg::CFG_IDX_W-1:0] CFG_IDX_LIM = cbal_pkg::CFG_IDX_W'(cbal_pkg::CFG_REGS);

  logic signed [15:0] cfg_reg [cbal_pkg::CFG_REGS];
  logic [1:0]         cmd_reg;
  logic [18:0]        value_reg;
  logic [TW-1:0]      t_reg;
  logic [TW-1:0]      u;
  logic [33:0]        uu;
  logic [33:0]        tt;
  logic [32:0]        w [4];
  logic signed [51:0] accx;
  logic signed [51:0] accy;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [33:0]        nsq;
  logic [33:0]        sq_n;
  logic [18:0]        sq_rem;
  logic [16:0]        sq_root;
  logic [20:0]        sq_r2;
  logic [20:0]        sq_trial;
  logic [LW-1:0]      total;
  logic [LW:0]        total_sum;
  logic [LW-1:0]      total_new;
  logic               ready;
  logic [LW-1:0]      d;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      run_start;
  logic [LW-1:0]      run_val;
  logic [LW-1:0]      span;
  logic [36:0]        num;
  logic [19:0]        dv_rem;
  logic [16:0]        dv_low;
  logic [16:0]        quo;
  logic [20:0]        dv_r2;
  logic [LW-1:0]      mem [0:cbal_pkg::SEGMENTS];
  logic [LW-1:0]      rdata;
  logic [IW-1:0]      mem_addr;
  logic               mem_we;
  logic [LW-1:0]      mem_wd;
  logic signed [35:0] ma;
  logic signed [17:0] mb;
  logic signed [53:0] prod;
  logic [cbal_pkg::MUL_W-1:0] tag;
  logic [53:0]        p3;
  logic [35:0]        fsum;
  logic [LW-1:0]      fq;
  logic [TW-1:0]      f;
  logic [TW-1:0]      dt;
  logic signed [51:0] rx;
  logic signed [51:0] ry;
  logic               hit;
  logic               idx_last;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] q);
    logic signed [15:0] r;
    if (q > 20'sd32767) r = 16'sh7FFF;
    else if (q < -20'sd32768) r = 16'sh8000;
    else r = q[15:0];
    return r;
  endfunction

  assign u        = cbal_pkg::ONE_Q16 - t_reg;
  assign dx       = 17'(pos_x) - 17'(prev_x);
  assign dy       = 17'(pos_y) - 17'(prev_y);
  assign f        = (value_reg > 19'(cbal_pkg::ONE_Q16)) ? cbal_pkg::ONE_Q16 : value_reg[16:0];
  assign dt       = cbal_pkg::sample_param(idx) - cbal_pkg::sample_param(run_start);
  assign hit      = (idx != '0) && (rdata > d);
  assign idx_last = (idx == IW'(cbal_pkg::SEGMENTS));
  assign rx       = accx + 52'sd2147483648;
  assign ry       = accy + 52'sd2147483648;

  assign sq_r2    = {sq_rem, sq_n[33:32]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign total_sum = {1'b0, total} + (LW+1)'(sq_root) + (LW+1)'(sq_rem > 19'(sq_root));
  assign total_new = total_sum[LW] ? cbal_pkg::LEN_MAX : total_sum[LW-1:0];

  assign dv_r2    = {dv_rem, dv_low[16]};

  assign stat.cmd        = cmd_reg;
  assign stat.value_over = value_reg > 19'(cbal_pkg::ONE_Q16);
  assign stat.ready      = ready;
  assign stat.hit        = hit;
  assign stat.idx_last   = idx_last;
  assign stat.out_busy   = m_tvalid && !m_tready;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul)
      cbal_pkg::M_UU:   begin ma = 36'(u);     mb = 18'(u);   end
      cbal_pkg::M_TT:   begin ma = 36'(t_reg); mb = 18'(t_reg); end
      cbal_pkg::M_UUU:  begin ma = 36'(uu);    mb = 18'(u);   end
      cbal_pkg::M_UUT:  begin ma = 36'(uu);    mb = 18'(t_reg); end
      cbal_pkg::M_UTT:  begin ma = 36'(tt);    mb = 18'(u);   end
      cbal_pkg::M_TTT:  begin ma = 36'(tt);    mb = 18'(t_reg); end
      cbal_pkg::M_W0X:  begin ma = 36'(w[0]);  mb = 18'(cfg_reg[0]); end
      cbal_pkg::M_W0Y:  begin ma = 36'(w[0]);  mb = 18'(cfg_reg[1]); end
      cbal_pkg::M_W1X:  begin ma = 36'(w[1]);  mb = 18'(cfg_reg[2]); end
      cbal_pkg::M_W1Y:  begin ma = 36'(w[1]);  mb = 18'(cfg_reg[3]); end
      cbal_pkg::M_W2X:  begin ma = 36'(w[2]);  mb = 18'(cfg_reg[4]); end
      cbal_pkg::M_W2Y:  begin ma = 36'(w[2]);  mb = 18'(cfg_reg[5]); end
      cbal_pkg::M_W3X:  begin ma = 36'(w[3]);  mb = 18'(cfg_reg[6]); end
      cbal_pkg::M_W3Y:  begin ma = 36'(w[3]);  mb = 18'(cfg_reg[7]); end
      cbal_pkg::M_DXX:  begin ma = 36'(dx);    mb = 18'(dx);  end
      cbal_pkg::M_DYY:  begin ma = 36'(dy);    mb = 18'(dy);  end
      cbal_pkg::M_FRAC: begin ma = 36'(total); mb = 18'(f);   end
      cbal_pkg::M_SPAN: begin ma = 36'(d - run_val); mb = 18'(dt); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign p3   = prod + (prod <<< 1);
  assign fsum = prod[35:0] + 36'd32768;
  assign fq   = fsum[34:16];

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) tag <= cbal_pkg::M_NONE;
    else tag <= cmd.mul;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbal_pkg::CFG_REGS; i++) cfg_reg[i] <= '0;
    end else if (cfg_valid && cfg_index < CFG_IDX_LIM) begin
      cfg_reg[cfg_index[2:0]] <= cfg_data;
    end
  end

  // product write-back
  always_ff @(posedge clk) begin
    if (cmd.mul == cbal_pkg::M_UU) begin
      accx <= '0;
      accy <= '0;
    end
    case (tag)
      cbal_pkg::M_UU:   uu <= prod[33:0];
      cbal_pkg::M_TT:   tt <= prod[33:0];
      cbal_pkg::M_UUU:  w[0] <= prod[48:16];
      cbal_pkg::M_UUT:  w[1] <= p3[48:16];
      cbal_pkg::M_UTT:  w[2] <= p3[48:16];
      cbal_pkg::M_TTT:  w[3] <= prod[48:16];
      cbal_pkg::M_W0X, cbal_pkg::M_W1X, cbal_pkg::M_W2X, cbal_pkg::M_W3X:
        accx <= accx + prod[51:0];
      cbal_pkg::M_W0Y, cbal_pkg::M_W1Y, cbal_pkg::M_W2Y, cbal_pkg::M_W3Y:
        accy <= accy + prod[51:0];
      cbal_pkg::M_DXX:  nsq <= prod[33:0];
      cbal_pkg::M_DYY:  nsq <= nsq + prod[33:0];
      cbal_pkg::M_SPAN: num <= prod[36:0] + 37'(span[LW-1:1]);
      default: ;
    endcase
  end

  // sequenced operations
  always_ff @(posedge clk) begin
    case (cmd.op)
      cbal_pkg::OP_LATCH: begin
        cmd_reg   <= s_tuser;
        value_reg <= s_tdata[18:0];
      end
      cbal_pkg::OP_T_SAMPLE: t_reg <= cbal_pkg::sample_param(idx);
      cbal_pkg::OP_T_VALUE:  t_reg <= value_reg[16:0];
      cbal_pkg::OP_T_INTERP: t_reg <= cbal_pkg::sample_param(run_start) + quo;
      cbal_pkg::OP_T_RUN:    t_reg <= cbal_pkg::sample_param(run_start);
      cbal_pkg::OP_ROUND: begin
        pos_x <= sat16(rx[51:32]);
        pos_y <= sat16(ry[51:32]);
      end
      cbal_pkg::OP_BUILD_INIT: begin
        idx   <= '0;
        total <= '0;
      end
      cbal_pkg::OP_PREV: begin
        prev_x <= pos_x;
        prev_y <= pos_y;
        idx    <= idx + 1'b1;
      end
      cbal_pkg::OP_SQRT_INIT: begin
        sq_n    <= nsq;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      cbal_pkg::OP_SQRT_STEP: begin
        sq_n <= {sq_n[31:0], 2'b00};
        if (sq_r2 >= sq_trial) begin
          sq_rem  <= 19'(sq_r2 - sq_trial);
          sq_root <= {sq_root[15:0], 1'b1};
        end else begin
          sq_rem  <= sq_r2[18:0];
          sq_root <= {sq_root[15:0], 1'b0};
        end
      end
      cbal_pkg::OP_ACCUM: total <= total_new;
      cbal_pkg::OP_DIST_VALUE: begin
        d   <= (value_reg > total) ? total : value_reg;
        idx <= '0;
      end
      cbal_pkg::OP_SCAN_INIT: idx <= '0;
      cbal_pkg::OP_SCAN_CHK: begin
        if (hit) begin
          span <= rdata - run_val;
        end else begin
          if (idx == '0 || rdata != run_val) begin
            run_start <= idx;
            run_val   <= rdata;
          end
          if (!idx_last) idx <= idx + 1'b1;
        end
      end
      cbal_pkg::OP_DIV_INIT: begin
        dv_rem <= num[36:17];
        dv_low <= num[16:0];
        quo    <= '0;
      end
      cbal_pkg::OP_DIV_STEP: begin
        dv_low <= {dv_low[15:0], 1'b0};
        if (dv_r2 >= 21'(span)) begin
          dv_rem <= 20'(dv_r2 - 21'(span));
          quo    <= {quo[15:0], 1'b1};
        end else begin
          dv_rem <= dv_r2[19:0];
          quo    <= {quo[15:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (tag == cbal_pkg::M_FRAC) d <= (fq > total) ? total : fq;
  end

  always_ff @(posedge clk) begin
    if (rst) ready <= 1'b0;
    else if (cmd.op == cbal_pkg::OP_READY) ready <= 1'b1;
  end

  // length table
  assign mem_we   = (cmd.op == cbal_pkg::OP_BUILD_INIT) || (cmd.op == cbal_pkg::OP_ACCUM);
  assign mem_addr = (cmd.op == cbal_pkg::OP_BUILD_INIT) ? '0 : idx;
  assign mem_wd   = (cmd.op == cbal_pkg::OP_BUILD_INIT) ? '0 : total_new;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rdata <= mem[mem_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata[15:0]  <= cmd.out_zero ? '0 : pos_x;
      m_tdata[31:16] <= cmd.out_zero ? '0 : pos_y;
      m_tdata[50:32] <= ready ? total : '0;
      m_tdata[55:51] <= '0;
      m_tuser        <= cmd.status;
    end
  end

endmodule

// ===== sv/cbal_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbal_ctrl
// Controller: sequences build, search, divide and curve evaluation.
// ----------------------------------------------------------------------------
module cbal_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output cbal_pkg::cbal_cmd_t  cmd,
  input  cbal_pkg::cbal_stat_t stat
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_EVAL   = 5'd2;
  localparam logic [4:0] S_B0     = 5'd3;
  localparam logic [4:0] S_B1     = 5'd4;
  localparam logic [4:0] S_B2     = 5'd5;
  localparam logic [4:0] S_B3     = 5'd6;
  localparam logic [4:0] S_B4     = 5'd7;
  localparam logic [4:0] S_B5     = 5'd8;
  localparam logic [4:0] S_B6     = 5'd9;
  localparam logic [4:0] S_SQRT   = 5'd10;
  localparam logic [4:0] S_B8     = 5'd11;
  localparam logic [4:0] S_B9     = 5'd12;
  localparam logic [4:0] S_FRAC_W = 5'd13;
  localparam logic [4:0] S_SCAN_W = 5'd14;
  localparam logic [4:0] S_SCAN_C = 5'd15;
  localparam logic [4:0] S_RUNT   = 5'd16;
  localparam logic [4:0] S_SPAN   = 5'd17;
  localparam logic [4:0] S_SPAN_W = 5'd18;
  localparam logic [4:0] S_DIV0   = 5'd19;
  localparam logic [4:0] S_DIV    = 5'd20;
  localparam logic [4:0] S_DIVT   = 5'd21;
  localparam logic [4:0] S_QOUT   = 5'd22;
  localparam logic [4:0] S_DONE   = 5'd23;

  logic [4:0] state, state_next;
  logic [4:0] ret, ret_next;
  logic [4:0] cnt, cnt_next;
  logic [cbal_pkg::ST_W-1:0] stc, stc_next;
  logic zero, zero_next;

  function automatic logic [cbal_pkg::MUL_W-1:0] eval_mul(input logic [4:0] c);
    logic [cbal_pkg::MUL_W-1:0] m;
    case (c)
      5'd0:  m = cbal_pkg::M_UU;
      5'd1:  m = cbal_pkg::M_TT;
      5'd2:  m = cbal_pkg::M_UUU;
      5'd3:  m = cbal_pkg::M_UUT;
      5'd4:  m = cbal_pkg::M_UTT;
      5'd5:  m = cbal_pkg::M_TTT;
      5'd6:  m = cbal_pkg::M_W0X;
      5'd7:  m = cbal_pkg::M_W0Y;
      5'd8:  m = cbal_pkg::M_W1X;
      5'd9:  m = cbal_pkg::M_W1Y;
      5'd10: m = cbal_pkg::M_W2X;
      5'd11: m = cbal_pkg::M_W2Y;
      5'd12: m = cbal_pkg::M_W3X;
      5'd13: m = cbal_pkg::M_W3Y;
      default: m = cbal_pkg::M_NONE;
    endcase
    return m;
  endfunction

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    cnt_next     = cnt;
    stc_next     = stc;
    zero_next    = zero;
    cmd.op       = cbal_pkg::OP_NOP;
    cmd.mul      = cbal_pkg::M_NONE;
    cmd.out_load = 1'b0;
    cmd.out_zero = zero;
    cmd.status   = stc;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = cbal_pkg::OP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        stc_next  = cbal_pkg::ST_OK;
        zero_next = 1'b1;
        if (stat.cmd == cbal_pkg::CMD_BUILD) begin
          cmd.op     = cbal_pkg::OP_BUILD_INIT;
          state_next = S_B0;
        end else if (!stat.ready) begin
          stc_next   = cbal_pkg::ST_NOT_BUILT;
          state_next = S_DONE;
        end else if (stat.cmd == cbal_pkg::CMD_PARAM) begin
          if (stat.value_over) begin
            stc_next   = cbal_pkg::ST_OVER;
            state_next = S_DONE;
          end else begin
            zero_next  = 1'b0;
            cmd.op     = cbal_pkg::OP_T_VALUE;
            ret_next   = S_QOUT;
            cnt_next   = '0;
            state_next = S_EVAL;
          end
        end else if (stat.cmd == cbal_pkg::CMD_DIST) begin
          zero_next  = 1'b0;
          cmd.op     = cbal_pkg::OP_DIST_VALUE;
          state_next = S_SCAN_W;
        end else begin
          zero_next  = 1'b0;
          cmd.mul    = cbal_pkg::M_FRAC;
          state_next = S_FRAC_W;
        end
      end
      S_EVAL: begin
        cmd.mul = eval_mul(cnt);
        if (cnt == 5'(cbal_pkg::EVAL_LAST)) begin
          cmd.op     = cbal_pkg::OP_ROUND;
          cnt_next   = '0;
          state_next = ret;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_B0: begin
        cmd.op     = cbal_pkg::OP_T_SAMPLE;
        ret_next   = S_B1;
        cnt_next   = '0;
        state_next = S_EVAL;
      end
      S_B1: begin
        cmd.op     = cbal_pkg::OP_PREV;
        state_next = S_B2;
      end
      S_B2: begin
        cmd.op     = cbal_pkg::OP_T_SAMPLE;
        ret_next   = S_B3;
        cnt_next   = '0;
        state_next = S_EVAL;
      end
      S_B3: begin
        cmd.mul    = cbal_pkg::M_DXX;
        state_next = S_B4;
      end
      S_B4: begin
        cmd.mul    = cbal_pkg::M_DYY;
        state_next = S_B5;
      end
      S_B5: state_next = S_B6;
      S_B6: begin
        cmd.op     = cbal_pkg::OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = cbal_pkg::OP_SQRT_STEP;
        if (cnt == 5'(cbal_pkg::SQRT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_B8;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_B8: begin
        cmd.op     = cbal_pkg::OP_ACCUM;
        state_next = stat.idx_last ? S_B9 : S_B1;
      end
      S_B9: begin
        cmd.op     = cbal_pkg::OP_READY;
        state_next = S_DONE;
      end
      S_FRAC_W: begin
        cmd.op     = cbal_pkg::OP_SCAN_INIT;
        state_next = S_SCAN_W;
      end
      S_SCAN_W: state_next = S_SCAN_C;
      S_SCAN_C: begin
        cmd.op = cbal_pkg::OP_SCAN_CHK;
        if (stat.hit) state_next = S_SPAN;
        else if (stat.idx_last) state_next = S_RUNT;
        else state_next = S_SCAN_W;
      end
      S_RUNT: begin
        cmd.op     = cbal_pkg::OP_T_RUN;
        ret_next   = S_QOUT;
        cnt_next   = '0;
        state_next = S_EVAL;
      end
      S_SPAN: begin
        cmd.mul    = cbal_pkg::M_SPAN;
        state_next = S_SPAN_W;
      end
      S_SPAN_W: state_next = S_DIV0;
      S_DIV0: begin
        cmd.op     = cbal_pkg::OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = cbal_pkg::OP_DIV_STEP;
        if (cnt == 5'(cbal_pkg::DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_DIVT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIVT: begin
        cmd.op     = cbal_pkg::OP_T_INTERP;
        ret_next   = S_QOUT;
        cnt_next   = '0;
        state_next = S_EVAL;
      end
      S_QOUT: state_next = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      cnt   <= '0;
      stc   <= cbal_pkg::ST_OK;
      zero  <= 1'b1;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      cnt   <= cnt_next;
      stc   <= stc_next;
      zero  <= zero_next;
    end
  end

endmodule

// ===== sv/cubic_bezier_arc_length_eval.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_arc_length_eval
// Cubic Bezier point evaluator with a built arc-length table for queries
// by parameter, by distance and by fraction of the total length.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tuser cmd, tdata value
//  m_*      out  m_tvalid/m_tready    tdata pos_x,pos_y,curve_length; tuser status
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item at a time through one shared 36x18 multiplier and a controller.
//  A distance or fraction query scans the length table entry by entry, then
//  runs 17 divide steps; a build measures 30 segments, 17 root steps each.
//  Reset clears the control state and the built flag; config is always ready.
//  A new item is taken while the last result waits in the output register.
// ----------------------------------------------------------------------------
module cubic_bezier_arc_length_eval (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // value[18:0], zero pad
  input  logic [cbal_pkg::CMD_W-1:0]     s_tuser,   // cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [55:0]                    m_tdata,   // pos_x, pos_y, curve_length, pad
  output logic [cbal_pkg::ST_W-1:0]      m_tuser,   // status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbal_pkg::COORD_W-1:0]   cfg_data
);

  cbal_pkg::cbal_cmd_t  cmd;
  cbal_pkg::cbal_stat_t stat;

  assign cfg_ready = 1'b1;

  cbal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  cbal_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== sv/cbal_check.sv =====
// ----------------------------------------------------------------------------
// cbal_check
// Port-level checks of the arc-length evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module cbal_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [55:0]               m_tdata,
  input logic [cbal_pkg::ST_W-1:0] m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("undefined status code");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != cbal_pkg::ST_OK |-> m_tdata[31:0] == 32'd0)
    else $error("flagged result carries a point");

  a_unbuilt_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == cbal_pkg::ST_NOT_BUILT |-> m_tdata[50:32] == 19'd0)
    else $error("length reported before any build");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

endmodule

bind cubic_bezier_arc_length_eval cbal_check u_cbal_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== verif/cubic_bezier_arc_length_eval_test.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_arc_length_eval_test
// Self-checking bench for the Bezier arc-length evaluator. Drives build,
// parameter, distance and fraction items through the stream port. Every
// result is checked against a bit-accurate predictor of the curve and its
// length table. Control points change between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cubic_bezier_arc_length_eval_test;

  localparam int LIMIT = 3000000;
  localparam int NRAND = 1200;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [18:0] curve_length;
    logic [1:0]  status;
  } point_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [18:0] value;
    logic        known;
    point_t      res;
  } row_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0, cfg_valid = 0;
  logic [23:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic [3:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic s_tready, m_tvalid, cfg_ready;
  logic [55:0] m_tdata;
  logic [1:0] m_tuser;

  cubic_bezier_arc_length_eval u_dut (.*);

  always #10 clk = ~clk;

  longint ctrl_pts[8];
  longint len_tab[31];
  bit tab_built;
  point_t pending_points[$];
  bit failed;
  int cycles;
  bit hold_off;

  function automatic longint t_of(int i);
    return (longint'(i) * 65536 + 15) / 30;
  endfunction

  function automatic longint rnd32(longint s);
    longint a, q;
    a = s + (longint'(1) << 31);
    if (a >= 0) q = a >>> 32;
    else q = -((-a + 64'hFFFFFFFF) >>> 32);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  task automatic curve_at(longint t, output longint px, output longint py);
    longint u, w0, w1, w2, w3;
    u = 65536 - t;
    w0 = (u * u * u) >>> 16;
    w1 = (3 * u * u * t) >>> 16;
    w2 = (3 * u * t * t) >>> 16;
    w3 = (t * t * t) >>> 16;
    px = rnd32(w0 * ctrl_pts[0] + w1 * ctrl_pts[2] + w2 * ctrl_pts[4] + w3 * ctrl_pts[6]);
    py = rnd32(w0 * ctrl_pts[1] + w1 * ctrl_pts[3] + w2 * ctrl_pts[5] + w3 * ctrl_pts[7]);
  endtask

  function automatic longint root_rounded(longint n);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    if (n - r * r > r) r++;
    return r;
  endfunction

  function automatic int lowest_equal(int j);
    while (j > 0 && len_tab[j-1] == len_tab[j]) j--;
    return j;
  endfunction

  function automatic longint t_at_distance(longint d);
    int i, k;
    longint lk, span, dt;
    for (i = 1; i <= 30; i++) if (len_tab[i] > d) break;
    if (i > 30) return t_of(lowest_equal(30));
    k = lowest_equal(i - 1);
    lk = len_tab[k];
    span = len_tab[i] - lk;
    dt = t_of(i) - t_of(k);
    return t_of(k) + ((d - lk) * dt + span / 2) / span;
  endfunction

  task automatic predict_point(logic [1:0] cmd, logic [18:0] value, output point_t r);
    longint px, py, x, y, lx, ly, total, d, f;
    px = 0; py = 0;
    r.status = cbal_pkg::ST_OK;
    if (cmd == cbal_pkg::CMD_BUILD) begin
      curve_at(0, lx, ly);
      total = 0;
      len_tab[0] = 0;
      for (int i = 1; i <= 30; i++) begin
        curve_at(t_of(i), x, y);
        total += root_rounded((x - lx) * (x - lx) + (y - ly) * (y - ly));
        if (total > 524287) total = 524287;
        len_tab[i] = total;
        lx = x; ly = y;
      end
      tab_built = 1;
    end else if (!tab_built) begin
      r.status = cbal_pkg::ST_NOT_BUILT;
    end else if (cmd == cbal_pkg::CMD_PARAM) begin
      if (value > 65536) r.status = cbal_pkg::ST_OVER;
      else curve_at(value, px, py);
    end else begin
      if (cmd == cbal_pkg::CMD_DIST) d = value;
      else begin
        f = value > 65536 ? 65536 : value;
        d = (f * len_tab[30] + 32768) >>> 16;
      end
      if (d > len_tab[30]) d = len_tab[30];
      curve_at(t_at_distance(d), px, py);
    end
    r.pos_x = px[15:0];
    r.pos_y = py[15:0];
    r.curve_length = tab_built ? len_tab[30][18:0] : '0;
  endtask

  task automatic write_ctrl(int idx, logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1; cfg_index <= idx[3:0]; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx < cbal_pkg::CFG_REGS) ctrl_pts[idx] = longint'($signed(v));
  endtask

  task automatic send_query(logic [1:0] cmd, logic [18:0] value, bit known, point_t res);
    point_t p;
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    predict_point(cmd, value, p);
    if (known && p != res) begin
      $error("table row mismatch: expected %h got %h", res, p);
      failed = 1;
    end
    pending_points.push_back(p);
    s_tvalid <= 1; s_tuser <= cmd; s_tdata <= {5'd0, value};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (1300) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int wait_n;
    forever begin
      wait_n = $urandom_range(0, 4);
      if (hold_off) begin
        wait_n = 3000;
        hold_off = 0;
      end
      if (wait_n != 0) begin
        m_tready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk) begin
    point_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.pos_x = m_tdata[15:0];
      got.pos_y = m_tdata[31:16];
      got.curve_length = m_tdata[50:32];
      got.status = m_tuser;
      if (pending_points.size() == 0) begin
        $error("result with none expected");
        failed = 1;
      end else begin
        want = pending_points.pop_front();
        if (got.pos_x != want.pos_x) begin
          $error("pos_x exp %h act %h", want.pos_x, got.pos_x); failed = 1;
        end
        if (got.pos_y != want.pos_y) begin
          $error("pos_y exp %h act %h", want.pos_y, got.pos_y); failed = 1;
        end
        if (got.curve_length != want.curve_length) begin
          $error("curve_length exp %h act %h", want.curve_length, got.curve_length);
          failed = 1;
        end
        if (got.status != want.status) begin
          $error("status exp %h act %h", want.status, got.status); failed = 1;
        end
      end
    end
  end

  row_t rows[$];
  point_t zero_pt;

  initial begin
    int c;
    logic [18:0] v;
    zero_pt = '0;
    foreach (ctrl_pts[i]) ctrl_pts[i] = 0;
    tab_built = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows.push_back('{cbal_pkg::CMD_PARAM, 19'd0, 1,
                     '{16'd0, 16'd0, 19'd0, cbal_pkg::ST_NOT_BUILT}});
    rows.push_back('{cbal_pkg::CMD_DIST, 19'h7FFFF, 1,
                     '{16'd0, 16'd0, 19'd0, cbal_pkg::ST_NOT_BUILT}});
    rows.push_back('{cbal_pkg::CMD_FRAC, 19'd65536, 1,
                     '{16'd0, 16'd0, 19'd0, cbal_pkg::ST_NOT_BUILT}});
    rows.push_back('{cbal_pkg::CMD_BUILD, 19'h7FFFF, 1, zero_pt});
    rows.push_back('{cbal_pkg::CMD_PARAM, 19'd65537, 1,
                     '{16'd0, 16'd0, 19'd0, cbal_pkg::ST_OVER}});
    rows.push_back('{cbal_pkg::CMD_DIST, 19'd100, 1, zero_pt});
    foreach (rows[i]) send_query(rows[i].cmd, rows[i].value, rows[i].known, rows[i].res);
    drain();

    write_ctrl(0, 16'h8000); write_ctrl(1, 16'h8000);
    write_ctrl(2, 16'h7FFF); write_ctrl(3, 16'h8000);
    write_ctrl(4, 16'h8000); write_ctrl(5, 16'h7FFF);
    write_ctrl(6, 16'h7FFF); write_ctrl(7, 16'h7FFF);
    write_ctrl(9, 16'h1234);
    rows.delete();
    rows.push_back('{cbal_pkg::CMD_PARAM, 19'd32768, 0, zero_pt});
    rows.push_back('{cbal_pkg::CMD_BUILD, 19'd0, 0, zero_pt});
    rows.push_back('{cbal_pkg::CMD_PARAM, 19'd0, 0, zero_pt});
    rows.push_back('{cbal_pkg::CMD_PARAM, 19'd65536, 0, zero_pt});
    rows.push_back('{cbal_pkg::CMD_PARAM, 19'h7FFFF, 0, zero_pt});
    rows.push_back('{cbal_pkg::CMD_DIST, 19'd0, 0, zero_pt});
    rows.push_back('{cbal_pkg::CMD_DIST, 19'h7FFFF, 0, zero_pt});
    rows.push_back('{cbal_pkg::CMD_FRAC, 19'd0, 0, zero_pt});
    rows.push_back('{cbal_pkg::CMD_FRAC, 19'd32768, 0, zero_pt});
    rows.push_back('{cbal_pkg::CMD_FRAC, 19'h7FFFF, 0, zero_pt});
    foreach (rows[i]) send_query(rows[i].cmd, rows[i].value, rows[i].known, rows[i].res);
    drain();

    // degenerate curve: all points equal, zero-length segments
    for (int i = 0; i < 8; i++) write_ctrl(i, 16'h0040);
    send_query(cbal_pkg::CMD_BUILD, 19'd0, 0, zero_pt);
    send_query(cbal_pkg::CMD_DIST, 19'd5, 0, zero_pt);
    send_query(cbal_pkg::CMD_FRAC, 19'd40000, 0, zero_pt);
    drain();
    // partially flat curve
    write_ctrl(6, 16'h0100);
    send_query(cbal_pkg::CMD_BUILD, 19'd0, 0, zero_pt);
    send_query(cbal_pkg::CMD_DIST, 19'd3, 0, zero_pt);
    drain();

    hold_off = 1;
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 8; i++)
        write_ctrl(i, (ph % 3 == 0) ? 16'($urandom) : 16'($signed(12'($urandom))));
      send_query(cbal_pkg::CMD_BUILD, 19'($urandom), 0, zero_pt);
      for (int n = 0; n < NRAND / 8; n++) begin
        c = $urandom_range(1, 3);
        if (n % 40 == 39) c = cbal_pkg::CMD_BUILD;
        case ($urandom_range(0, 3))
          0: v = 19'($urandom);
          1: v = 19'($urandom_range(0, 65536));
          2: v = 19'($urandom_range(0, len_tab[30] + 2));
          default: v = 19'($urandom_range(65530, 65540));
        endcase
        send_query(c[1:0], v, 0, zero_pt);
      end
      drain();
    end

    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== cubic_bezier_arc_length_eval.f =====
sv/cbal_pkg.sv
sv/cbal_dp.sv
sv/cbal_ctrl.sv
sv/cubic_bezier_arc_length_eval.sv
sv/cbal_check.sv
verif/cubic_bezier_arc_length_eval_test.sv
